>>> hdl/rol_pkg.sv
`default_nettype none

package rol_pkg;

   // Fixed field widths.
   localparam int DIST_W     = 16;
   localparam int LABEL_W    = 12;
   localparam int POS_W      = 10;
   localparam int COLS_REG_W = 11;
   localparam int CSR_DATA_W = 16;

   // Defaults for the top level parameters.
   localparam int MAX_COLS_DEF   = 1024;
   localparam int MAX_ROWS_DEF   = 1024;
   localparam int MAX_LABELS_DEF = 4095;

   // Register reset values.
   localparam logic [DIST_W-1:0]     MIN_DIST_RESET = 16'd256;
   localparam logic [COLS_REG_W-1:0] COLS_RESET     = 11'd1024;

   // Label and row index ceilings set by the field widths.
   localparam int LABEL_TOP = 4095;
   localparam int POS_TOP   = 1023;

   typedef enum logic [0:0] {
      CSR_MIN_DIST    = 1'b0,
      CSR_COLS_IN_USE = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

>>> hdl/rol_req_if.sv
`default_nettype none

interface rol_req_if;
   logic                        valid;
   logic                        ready;
   logic [rol_pkg::DIST_W-1:0]  distance;
   logic                        in_map;
   logic                        frame_start;

   modport source (output valid, output distance, output in_map, output frame_start,
                   input ready);
   modport sink   (input valid, input distance, input in_map, input frame_start,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/rol_rsp_if.sv
`default_nettype none

interface rol_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rol_pkg::LABEL_W-1:0] label;
   logic                        is_obstacle;
   logic                        new_label;
   logic                        overflow;
   logic [rol_pkg::POS_W-1:0]   col;
   logic [rol_pkg::POS_W-1:0]   row;

   modport source (output valid, output label, output is_obstacle, output new_label,
                   output overflow, output col, output row, input ready);
   modport sink   (input valid, input label, input is_obstacle, input new_label,
                   input overflow, input col, input row, output ready);
endinterface

`default_nettype wire

>>> hdl/rol_line_buf.sv
`default_nettype none

// Labels of the previous row: one write port and two registered read ports.
module rol_line_buf #(
   parameter int DEPTH = rol_pkg::MAX_COLS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire logic [rol_pkg::LABEL_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr_b,
   output logic      [rol_pkg::LABEL_W-1:0] rd_data_a,
   output logic      [rol_pkg::LABEL_W-1:0] rd_data_b
);

   logic [rol_pkg::LABEL_W-1:0] label_mem [DEPTH];
   logic [rol_pkg::LABEL_W-1:0] rd_a_ff;
   logic [rol_pkg::LABEL_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         label_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= label_mem[rd_addr_a];
         rd_b_ff <= label_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

>>> hdl/raster_obstacle_labeler_core.sv
`default_nettype none

// Channel   Dir  Contents
// req_chan  in   distance, in_map, frame_start (one grid cell, raster order)
// rsp_chan  out  label, is_obstacle, new_label, overflow, col, row
// csr_*     in   write enable, register index, write data (threshold, cols_in_use)
//
// One cell is accepted per cycle while input is not stalled, and its result is in the output
// register in the next cycle.
// The next cell's two upper neighbors are read from the line buffer when a cell is
// accepted. A write to cols_in_use stops input while that read is redone.
// Reset is synchronous: it clears position and label counter and reloads the registers, not the buffer.
// Input stalls while the output register is full and the result side holds off, and during that reread.
module raster_obstacle_labeler_core #(
   parameter int MAX_COLS   = rol_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS   = rol_pkg::MAX_ROWS_DEF,
   parameter int MAX_LABELS = rol_pkg::MAX_LABELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rol_req_if.sink                             req_chan,
   rol_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire rol_pkg::csr_index_type         csr_index,
   input  wire logic [rol_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW       = $clog2(MAX_COLS);
   localparam int CW       = $clog2(MAX_COLS + 1);
   localparam int LabelCap = (MAX_LABELS < rol_pkg::LABEL_TOP) ? MAX_LABELS
                                                               : rol_pkg::LABEL_TOP;
   localparam int RowTop   = ((MAX_ROWS - 1) < rol_pkg::POS_TOP) ? (MAX_ROWS - 1)
                                                                : rol_pkg::POS_TOP;
   localparam int LW       = rol_pkg::LABEL_W;
   localparam int PW       = rol_pkg::POS_W;

   // Configuration.
   logic [rol_pkg::DIST_W-1:0]     thresh_ff, thresh_in;
   logic [rol_pkg::COLS_REG_W-1:0] cols_ff, cols_in;
   logic                           refill_ff, refill_in;

   // Scan state.
   logic [AW-1:0] col_count_ff, col_count_in;
   logic [PW-1:0] row_count_ff, row_count_in;
   logic [LW-1:0] label_count_ff, label_count_in;
   logic [LW-1:0] left_ff, left_in;
   logic [LW-1:0] upleft_ff, upleft_in;
   logic          byp_a_ff, byp_a_in;
   logic          byp_b_ff, byp_b_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] rsp_label_ff, rsp_label_in;
   logic          rsp_obst_ff, rsp_obst_in;
   logic          rsp_new_ff, rsp_new_in;
   logic          rsp_over_ff, rsp_over_in;
   logic [PW-1:0] rsp_col_ff, rsp_col_in;
   logic [PW-1:0] rsp_row_ff, rsp_row_in;

   // Step logic.
   logic          accept;
   logic          do_refill;
   logic          refill_wrap;
   logic [CW-1:0] cols_eff;
   logic [AW-1:0] col_cur;
   logic [PW-1:0] row_cur;
   logic [PW-1:0] row_cur_inc;
   logic [PW-1:0] row_ff_inc;
   logic [LW-1:0] lc_cur;
   logic [CW-1:0] col_p1;
   logic          row_nz;
   logic          col_nz;
   logic [LW-1:0] above;
   logic [LW-1:0] upright;
   logic [LW-1:0] left;
   logic [LW-1:0] upleft;
   logic          obstacle;
   logic [LW-1:0] label;
   logic          fresh;
   logic          over;
   logic [LW-1:0] lc_next;
   logic          wrap;

   // Line buffer ports.
   logic          rd_en;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   logic [LW-1:0] rd_data_a;
   logic [LW-1:0] rd_data_b;

   assign req_chan.ready = !refill_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign do_refill      = refill_ff && !csr_we;

   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_ff);
      end
   end

   // Cell classification and label choice.
   always_comb begin
      col_cur     = req_chan.frame_start ? '0 : col_count_ff;
      row_cur     = req_chan.frame_start ? '0 : row_count_ff;
      lc_cur      = req_chan.frame_start ? '0 : label_count_ff;
      row_nz      = (row_cur != '0);
      col_nz      = (col_cur != '0);
      col_p1      = CW'(col_cur) + CW'(1);
      row_cur_inc = (32'(row_cur) < RowTop) ? row_cur + PW'(1) : row_cur;
      // A bypass flag means the window entry was written in the same cycle it
      // was read, so the fresh value is the last result label.
      above   = !row_nz ? '0 : (byp_a_ff ? rsp_label_ff : rd_data_a);
      upright = (!row_nz || (col_p1 >= cols_eff)) ? '0
                                                  : (byp_b_ff ? rsp_label_ff : rd_data_b);
      left    = col_nz ? left_ff : '0;
      upleft  = (col_nz && row_nz) ? upleft_ff : '0;

      obstacle = req_chan.in_map && (req_chan.distance < thresh_ff);
      label    = '0;
      fresh    = 1'b0;
      over     = 1'b0;
      lc_next  = lc_cur;
      if (obstacle) begin
         if (above != '0) begin
            label = above;
         end else if (left != '0) begin
            label = left;
         end else if (upleft != '0) begin
            label = upleft;
         end else if (upright != '0) begin
            label = upright;
         end else if (32'(lc_cur) < LabelCap) begin
            lc_next = lc_cur + LW'(1);
            label   = lc_next;
            fresh   = 1'b1;
         end else begin
            over = 1'b1;
         end
      end
      wrap = (col_p1 >= cols_eff);
   end

   // Reload after a change of row length: a position past the new row end
   // moves to the start of the next row first.
   assign refill_wrap = (CW'(col_count_ff) >= cols_eff);
   assign row_ff_inc  = (32'(row_count_ff) < RowTop) ? row_count_ff + PW'(1) : row_count_ff;

   always_comb begin
      rd_en = accept || do_refill;
      if (accept) begin
         rd_addr_a = wrap ? '0 : AW'(col_p1);
         rd_addr_b = wrap ? AW'(1) : col_cur + AW'(2);
      end else begin
         rd_addr_a = refill_wrap ? '0 : col_count_ff;
         rd_addr_b = refill_wrap ? AW'(1) : col_count_ff + AW'(1);
      end
   end

   // Next state.
   always_comb begin
      thresh_in      = thresh_ff;
      cols_in        = cols_ff;
      refill_in      = refill_ff;
      col_count_in   = col_count_ff;
      row_count_in   = row_count_ff;
      label_count_in = label_count_ff;
      left_in        = left_ff;
      upleft_in      = upleft_ff;
      byp_a_in       = byp_a_ff;
      byp_b_in       = byp_b_ff;
      rsp_label_in   = rsp_label_ff;
      rsp_obst_in    = rsp_obst_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_over_in    = rsp_over_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_valid_in   = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      if (do_refill) begin
         refill_in = 1'b0;
      end
      if (csr_we) begin
         case (csr_index)
            rol_pkg::CSR_MIN_DIST: begin
               thresh_in = csr_wdata;
            end
            rol_pkg::CSR_COLS_IN_USE: begin
               cols_in   = csr_wdata[rol_pkg::COLS_REG_W-1:0];
               refill_in = 1'b1;
            end
            default: begin
               thresh_in = thresh_ff;
            end
         endcase
      end

      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_label_in   = label;
         rsp_obst_in    = obstacle;
         rsp_new_in     = fresh;
         rsp_over_in    = over;
         rsp_col_in     = PW'(col_cur);
         rsp_row_in     = row_cur;
         label_count_in = lc_next;
         col_count_in   = wrap ? '0 : AW'(col_p1);
         row_count_in   = wrap ? row_cur_inc : row_cur;
         left_in        = wrap ? '0 : label;
         upleft_in      = wrap ? '0 : above;
         byp_a_in       = wrap && !col_nz;
         byp_b_in       = wrap && (col_cur == AW'(1));
      end else if (do_refill) begin
         byp_a_in = 1'b0;
         byp_b_in = 1'b0;
         if (refill_wrap) begin
            col_count_in = '0;
            row_count_in = row_ff_inc;
            left_in      = '0;
            upleft_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff      <= rol_pkg::MIN_DIST_RESET;
         cols_ff        <= rol_pkg::COLS_RESET;
         refill_ff      <= 1'b0;
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         label_count_ff <= '0;
         left_ff        <= '0;
         upleft_ff      <= '0;
         byp_a_ff       <= 1'b0;
         byp_b_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         thresh_ff      <= thresh_in;
         cols_ff        <= cols_in;
         refill_ff      <= refill_in;
         col_count_ff   <= col_count_in;
         row_count_ff   <= row_count_in;
         label_count_ff <= label_count_in;
         left_ff        <= left_in;
         upleft_ff      <= upleft_in;
         byp_a_ff       <= byp_a_in;
         byp_b_ff       <= byp_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_label_ff <= rsp_label_in;
      rsp_obst_ff  <= rsp_obst_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

   rol_line_buf #(
      .DEPTH (MAX_COLS)
   ) u_line_buf (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col_cur),
      .wr_data   (label),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.label       = rsp_label_ff;
   assign rsp_chan.is_obstacle = rsp_obst_ff;
   assign rsp_chan.new_label   = rsp_new_ff;
   assign rsp_chan.overflow    = rsp_over_ff;
   assign rsp_chan.col         = rsp_col_ff;
   assign rsp_chan.row         = rsp_row_ff;

endmodule

`default_nettype wire
